>>> hw/rtl/bbus_pkg.sv
// ----------------------------------------------------------------------------
// bbus_pkg: shared types and constants for the RGB unsharp-mask sharpener
// Register indexes, field widths, the divide-by-nine reciprocal and the
// classified word passed from the front end to the filter pipeline.
// ----------------------------------------------------------------------------
package bbus_pkg;

   // Default maximum frame size; the width also sizes the line stores
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   // Register reset values (clamped to the sizing on use)
   localparam int IMAGE_WIDTH_RESET  = 1024;
   localparam int IMAGE_HEIGHT_RESET = 1024;

   // Register port
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 13;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } csr_reg_type;

   // Pixel and arithmetic widths
   localparam int PIX_W = 8;
   localparam int RGB_W = 3 * PIX_W;
   localparam int SUM_W = 12;                 // nine bytes sum to at most 2295

   // floor(n / 9) = (n * 7282) >> 16 for every n below 32768
   localparam int          DIV9_MULT_W = 13;
   localparam logic [12:0] DIV9_MULT   = 13'd7282;
   localparam int          DIV9_SHIFT  = 16;

   // Words held between front end and filter pipeline
   localparam int QUEUE_DEPTH = 4;

   // One classified word: pixel plus what the filter needs to know of it
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             emit;         // a result leaves with this word
      logic             last;         // that result closes the frame
      logic             top_edge;     // drop the row above the centre
      logic             bottom_edge;  // drop the row below the centre
      logic             left_edge;    // drop the column left of the centre
      logic             right_edge;   // drop the column right of the centre
   } bbus_item_type;

endpackage

>>> hw/rtl/bbus_front.sv
// ----------------------------------------------------------------------------
// bbus_front: input acceptance, frame counters and register file
// Tracks input and output raster positions, drops early flush ticks and
// tags every kept word with its emit, frame-end and border flags.
// ----------------------------------------------------------------------------
module bbus_front #(
   parameter int MAX_WIDTH  = bbus_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bbus_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bbus_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bbus_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [bbus_pkg::PIX_W-1:0]        req_red_in,
   input  logic [bbus_pkg::PIX_W-1:0]        req_green_in,
   input  logic [bbus_pkg::PIX_W-1:0]        req_blue_in,
   output logic                              push_valid,
   input  logic                              push_ready,
   output logic [$clog2(MAX_WIDTH)-1:0]      push_col,
   output bbus_pkg::bbus_item_type           push_item
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int ORW = $clog2(MAX_HEIGHT);
   localparam int W_RESET = (bbus_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                            MAX_WIDTH : bbus_pkg::IMAGE_WIDTH_RESET;
   localparam int H_RESET = (bbus_pkg::IMAGE_HEIGHT_RESET > MAX_HEIGHT) ?
                            MAX_HEIGHT : bbus_pkg::IMAGE_HEIGHT_RESET;

   logic [WW-1:0]  image_width_ff,  image_width_in;
   logic [HW-1:0]  image_height_ff, image_height_in;
   logic [CW-1:0]  in_col_ff,  in_col_in;
   logic [RW-1:0]  in_row_ff,  in_row_in;
   logic [CW-1:0]  out_col_ff, out_col_in;
   logic [ORW-1:0] out_row_ff, out_row_in;

   logic [CW:0]    width_ext;
   logic [RW-1:0]  height_ext;
   logic [CW:0]    in_col_inc;
   logic [CW:0]    out_col_inc;
   logic [RW-1:0]  out_row_inc;
   logic           active;
   logic           ignored;
   logic           accept;
   logic           emit;
   logic           last;
   logic [31:0]    raw_width;
   logic [31:0]    raw_height;
   logic [WW-1:0]  clamp_width;
   logic [HW-1:0]  clamp_height;

   // Classify the offered word
   always_comb begin
      width_ext   = (CW+1)'(image_width_ff);
      height_ext  = RW'(image_height_ff);
      in_col_inc  = {1'b0, in_col_ff} + 1'b1;
      out_col_inc = {1'b0, out_col_ff} + 1'b1;
      out_row_inc = RW'(out_row_ff) + 1'b1;
      active      = in_row_ff < height_ext;
      ignored     = active && req_action;
      accept      = req_valid && push_ready;
      emit        = (in_row_ff >= RW'(2)) ||
                    ((in_row_ff == RW'(1)) && (in_col_ff != '0));
      last        = emit && (out_row_inc == height_ext) && (out_col_inc == width_ext);
   end

   // Build the word for the filter; past the last row the pixel is zero
   always_comb begin
      req_ready              = push_ready;
      push_valid             = accept && !ignored;
      push_col               = in_col_ff;
      push_item.red          = active ? req_red_in   : '0;
      push_item.green        = active ? req_green_in : '0;
      push_item.blue         = active ? req_blue_in  : '0;
      push_item.emit         = emit;
      push_item.last         = last;
      push_item.top_edge     = (out_row_ff == '0);
      push_item.bottom_edge  = (out_row_inc >= height_ext);
      push_item.left_edge    = (out_col_ff == '0);
      push_item.right_edge   = (out_col_inc >= width_ext) || (in_col_ff == '0);
   end

   // Clamp register writes to 1..maximum
   always_comb begin
      raw_width  = 32'(csr_wdata[bbus_pkg::WIDTH_REG_BITS-1:0]);
      raw_height = 32'(csr_wdata[bbus_pkg::HEIGHT_REG_BITS-1:0]);
      if (raw_width == 32'd0) begin
         clamp_width = WW'(1);
      end else if (raw_width > 32'(MAX_WIDTH)) begin
         clamp_width = WW'(MAX_WIDTH);
      end else begin
         clamp_width = WW'(raw_width);
      end
      if (raw_height == 32'd0) begin
         clamp_height = HW'(1);
      end else if (raw_height > 32'(MAX_HEIGHT)) begin
         clamp_height = HW'(MAX_HEIGHT);
      end else begin
         clamp_height = HW'(raw_height);
      end
   end

   // Advance the raster counters; restart on frame end or a size register write
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      if (accept && !ignored) begin
         if (in_col_inc >= width_ext) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_inc[CW-1:0];
         end
         if (emit) begin
            if (out_col_inc >= width_ext) begin
               out_col_in = '0;
               out_row_in = ORW'(out_row_inc);
            end else begin
               out_col_in = out_col_inc[CW-1:0];
            end
         end
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
      if (csr_write_en) begin
         case (csr_index)
            bbus_pkg::REG_IMAGE_WIDTH: begin
               image_width_in = clamp_width;
               in_col_in      = '0;
               in_row_in      = '0;
               out_col_in     = '0;
               out_row_in     = '0;
            end
            bbus_pkg::REG_IMAGE_HEIGHT: begin
               image_height_in = clamp_height;
               in_col_in       = '0;
               in_row_in       = '0;
               out_col_in      = '0;
               out_row_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WW'(W_RESET);
         image_height_ff <= HW'(H_RESET);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
      end
   end

endmodule

>>> hw/rtl/bbus_queue.sv
// ----------------------------------------------------------------------------
// bbus_queue: short word queue between front end and filter pipeline
// Register-based FIFO; lets either side stall without holding the other.
// ----------------------------------------------------------------------------
module bbus_queue #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = bbus_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff,  count_in;
   logic              do_push;
   logic              do_pop;

   // Work out flags and pointer moves
   always_comb begin
      push_ready = count_ff != NW'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = store_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/bbus_back.sv
// ----------------------------------------------------------------------------
// bbus_back: line stores, 3x3 window and sharpening pipeline
// Pop -> line store read -> window shift -> masked sums -> divide by nine
// and 2*centre minus blur -> result register. All stages stall together
// when the result is not taken.
// ----------------------------------------------------------------------------
module bbus_back #(
   parameter int MAX_WIDTH = bbus_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_pop,
   input  logic [$clog2(MAX_WIDTH)-1:0]     q_col,
   input  bbus_pkg::bbus_item_type          q_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bbus_pkg::PIX_W-1:0]       rsp_red_out,
   output logic [bbus_pkg::PIX_W-1:0]       rsp_green_out,
   output logic [bbus_pkg::PIX_W-1:0]       rsp_blue_out,
   output logic                             rsp_frame_end
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int PIX_W = bbus_pkg::PIX_W;
   localparam int RGB_W = bbus_pkg::RGB_W;
   localparam int SUM_W = bbus_pkg::SUM_W;
   localparam int PRD_W = SUM_W + bbus_pkg::DIV9_MULT_W;
   localparam int LW    = 2 * RGB_W;

   // Line stores: upper in the high half, middle in the low half
   logic [LW-1:0] line_mem [MAX_WIDTH];

   logic                      adv;
   logic                      line_wr_en;
   logic [LW-1:0]             line_wdata;
   logic [LW-1:0]             line_word;
   logic [2:0][RGB_W-1:0]     fresh;

   logic                      b_valid_ff,  b_valid_in;
   logic [CW-1:0]             b_col_ff,    b_col_in;
   bbus_pkg::bbus_item_type   b_item_ff,   b_item_in;
   logic [LW-1:0]             rd_ff;
   logic                      byp_ff,      byp_in;
   logic [LW-1:0]             byp_data_ff, byp_data_in;
   logic [2:0][2:0][RGB_W-1:0] win_ff,     win_in;

   logic                      c_valid_ff,  c_valid_in;
   bbus_pkg::bbus_item_type   c_item_ff,   c_item_in;
   logic [2:0]                row_ok;
   logic [2:0]                col_ok;

   logic                      d_valid_ff,  d_valid_in;
   logic [2:0][SUM_W-1:0]     d_sum_ff,    d_sum_in;
   logic [2:0][PIX_W-1:0]     d_mid_ff,    d_mid_in;
   logic                      d_last_ff,   d_last_in;

   logic [PRD_W-1:0]          prod [3];
   logic [2:0][PIX_W-1:0]     sharp;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0][PIX_W-1:0]     rsp_pix_ff,   rsp_pix_in;
   logic                      rsp_last_ff,  rsp_last_in;

   // Whole pipeline moves unless a result waits
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   // Pop stage: take the next word and issue the line store read
   always_comb begin
      b_valid_in = adv ? q_pop : b_valid_ff;
      b_col_in   = q_pop ? q_col  : b_col_ff;
      b_item_in  = q_pop ? q_item : b_item_ff;
   end

   // Read stage: forward a same-column write, shift the window, rewrite stores
   always_comb begin
      line_word   = byp_ff ? byp_data_ff : rd_ff;
      fresh[0]    = line_word[LW-1:RGB_W];
      fresh[1]    = line_word[RGB_W-1:0];
      fresh[2]    = {b_item_ff.red, b_item_ff.green, b_item_ff.blue};
      line_wr_en  = adv && b_valid_ff;
      line_wdata  = {fresh[1], fresh[2]};
      byp_in      = q_pop && b_valid_ff && (b_col_ff == q_col);
      byp_data_in = line_wdata;
      win_in      = win_ff;
      if (line_wr_en) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
            win_in[r][2] = fresh[r];
         end
      end
      c_valid_in = adv ? (b_valid_ff && b_item_ff.emit) : c_valid_ff;
      c_item_in  = adv ? b_item_ff : c_item_ff;
   end

   // Sum stage: masked 3x3 sums around the window centre
   always_comb begin
      row_ok = {!c_item_ff.bottom_edge, 1'b1, !c_item_ff.top_edge};
      col_ok = {!c_item_ff.right_edge,  1'b1, !c_item_ff.left_edge};
      for (int ch = 0; ch < 3; ch++) begin
         d_sum_in[ch] = d_sum_ff[ch];
         d_mid_in[ch] = d_mid_ff[ch];
      end
      d_last_in  = d_last_ff;
      d_valid_in = d_valid_ff;
      if (adv) begin
         d_valid_in = c_valid_ff;
         d_last_in  = c_item_ff.last;
         for (int ch = 0; ch < 3; ch++) begin
            d_sum_in[ch] = '0;
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  if (row_ok[r] && col_ok[c]) begin
                     d_sum_in[ch] = d_sum_in[ch] +
                        SUM_W'(win_ff[r][c][PIX_W*(2-ch) +: PIX_W]);
                  end
               end
            end
            d_mid_in[ch] = win_ff[1][1][PIX_W*(2-ch) +: PIX_W];
         end
      end
   end

   // Sharpen stage: blur by reciprocal, then 2*centre minus blur
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch]  = PRD_W'(d_sum_ff[ch]) * PRD_W'(bbus_pkg::DIV9_MULT);
         sharp[ch] = PIX_W'({d_mid_ff[ch], 1'b0} -
                            {1'b0, prod[ch][bbus_pkg::DIV9_SHIFT +: PIX_W]});
      end
      rsp_valid_in = adv ? d_valid_ff : rsp_valid_ff;
      rsp_pix_in   = adv ? sharp      : rsp_pix_ff;
      rsp_last_in  = adv ? d_last_ff  : rsp_last_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff[0];
   assign rsp_green_out = rsp_pix_ff[1];
   assign rsp_blue_out  = rsp_pix_ff[2];
   assign rsp_frame_end = rsp_last_ff;

   // Line store write and registered read
   always_ff @(posedge clock) begin
      if (line_wr_en) begin
         line_mem[b_col_ff] <= line_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= line_mem[q_col];
      end
   end

   // Control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         win_ff       <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         byp_ff       <= adv ? byp_in : byp_ff;
         win_ff       <= win_in;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      b_col_ff    <= b_col_in;
      b_item_ff   <= b_item_in;
      byp_data_ff <= adv ? byp_data_in : byp_data_ff;
      c_item_ff   <= c_item_in;
      d_sum_ff    <= d_sum_in;
      d_mid_ff    <= d_mid_in;
      d_last_ff   <= d_last_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> hw/rtl/box_blur_unsharp_sharpen_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_unsharp_sharpen_rgb: streaming 3x3 unsharp-mask sharpener, RGB
// Sharpens raster-order RGB pixels with 2*centre minus a zero-padded 3x3 box
// blur, per channel, wrapped to 8 bits.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and gives one result per clock
// in steady state while results are taken. A result leaves one row plus one
// pixel after its input pixel; flush words (action high) after the last
// pixel of the frame drain the final row, and frame_end marks the frame's
// last result. Flush words sent before the last pixel are accepted and
// dropped. From acceptance a word passes a four-word queue and then four
// clocked steps (pop with line store read, window shift, sums, sharpen)
// before the result that it releases shows; the line stores are one
// memory with one read and one write port per clock, read and rewritten
// at the current column. A stalled result halts the filter pipeline only;
// the queue keeps taking input until it is full. Writing image_width or
// image_height restarts the frame and must be done with the block idle.
// The line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module box_blur_unsharp_sharpen_rgb #(
   parameter int MAX_WIDTH  = bbus_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bbus_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [bbus_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbus_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [bbus_pkg::PIX_W-1:0]      req_red_in,
   input  logic [bbus_pkg::PIX_W-1:0]      req_green_in,
   input  logic [bbus_pkg::PIX_W-1:0]      req_blue_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bbus_pkg::PIX_W-1:0]      rsp_red_out,
   output logic [bbus_pkg::PIX_W-1:0]      rsp_green_out,
   output logic [bbus_pkg::PIX_W-1:0]      rsp_blue_out,
   output logic                            rsp_frame_end
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int ITEM_W = $bits(bbus_pkg::bbus_item_type);
   localparam int QW     = CW + ITEM_W;

   logic                    push_valid;
   logic                    push_ready;
   logic [CW-1:0]           push_col;
   bbus_pkg::bbus_item_type push_item;
   logic                    pop_valid;
   logic                    pop_ready;
   logic [QW-1:0]           pop_data;
   logic [CW-1:0]           pop_col;
   bbus_pkg::bbus_item_type pop_item;

   // Front end: accept, count and classify
   bbus_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_col     (push_col),
      .push_item    (push_item)
   );

   // Queue between the two halves
   bbus_queue #(
      .DATA_W (QW),
      .DEPTH  (bbus_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_col, push_item}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Split the queued word
   assign pop_col  = pop_data[ITEM_W +: CW];
   assign pop_item = bbus_pkg::bbus_item_type'(pop_data[ITEM_W-1:0]);

   // Filter pipeline and result register
   bbus_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (pop_valid),
      .q_pop         (pop_ready),
      .q_col         (pop_col),
      .q_item        (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RGB unsharp-mask sharpener
// Drives raster pixel words and flush words through the valid/ready input,
// programs the frame size through the register port between phases, and
// checks every unpinned result word against an in-bench model of the line
// stores, the 3x3 window and the sharpening arithmetic. A short directed
// table runs first, then random frames of many sizes with random idling.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_W           = bbus_pkg::MAX_WIDTH_DEFAULT;
   localparam int MAX_H           = bbus_pkg::MAX_HEIGHT_DEFAULT;
   localparam int CSR_IDX_W       = bbus_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W      = bbus_pkg::CSR_DATA_W;
   localparam int WIDTH_REG_BITS  = bbus_pkg::WIDTH_REG_BITS;
   localparam int HEIGHT_REG_BITS = bbus_pkg::HEIGHT_REG_BITS;
   localparam int PIX_W           = bbus_pkg::PIX_W;
   localparam int RGB_W           = bbus_pkg::RGB_W;
   localparam int RANDOM_ITEMS    = 1000;
   localparam int QUIET_CYCLES    = 32;   // queue plus pipeline, with margin

   // Indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

   typedef enum logic {ACT_PIXEL = 1'b0, ACT_FLUSH = 1'b1} action_type;
   typedef enum logic {ROW_WORD, ROW_REG} row_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_end;
   } sharp_pixel_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      action_type            act;
      logic [PIX_W-1:0]      red;
      logic [PIX_W-1:0]      green;
      logic [PIX_W-1:0]      blue;
      bit                    pinned;
      sharp_pixel_type       want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = 1'b0;
   logic [PIX_W-1:0]      req_red_in = '0;
   logic [PIX_W-1:0]      req_green_in = '0;
   logic [PIX_W-1:0]      req_blue_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_red_out;
   logic [PIX_W-1:0]      rsp_green_out;
   logic [PIX_W-1:0]      rsp_blue_out;
   logic                  rsp_frame_end;

   // Typed expectation travelling with the word on the input channel
   logic                  pin_valid = 1'b0;
   sharp_pixel_type       pin_want = '0;

   box_blur_unsharp_sharpen_rgb dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sharpener model: line stores, window, counters and frame size
   // ------------------------------------------------------------------------
   logic [RGB_W-1:0] line_top [MAX_W];
   logic [RGB_W-1:0] line_mid [MAX_W];
   logic [RGB_W-1:0] nbhd [3][3];
   int unsigned      in_x, in_y, out_x, out_y;
   int unsigned      frame_w, frame_h;

   sharp_pixel_type  pending_pixels [$];
   sharp_pixel_type  predicted;
   sharp_pixel_type  head;
   int               mismatch_count = 0;
   int               stim_count = 0;
   bit               steady = 1'b0;
   int               hold_left = 0;
   stim_row_type     directed_rows [$];

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_counters();
      in_x = 0;
      in_y = 0;
      out_x = 0;
      out_y = 0;
   endfunction

   function automatic void reset_sharpener();
      for (int i = 0; i < MAX_W; i++) begin
         line_top[i] = '0;
         line_mid[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            nbhd[r][c] = '0;
      frame_w = clamp_dim(bbus_pkg::IMAGE_WIDTH_RESET, MAX_W);
      frame_h = clamp_dim(bbus_pkg::IMAGE_HEIGHT_RESET, MAX_H);
      restart_counters();
   endfunction

   // Any write to a real register abandons the frame in progress
   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      if (idx == bbus_pkg::REG_IMAGE_WIDTH) begin
         frame_w = clamp_dim(data[WIDTH_REG_BITS-1:0], MAX_W);
         restart_counters();
      end else if (idx == bbus_pkg::REG_IMAGE_HEIGHT) begin
         frame_h = clamp_dim(data[HEIGHT_REG_BITS-1:0], MAX_H);
         restart_counters();
      end
   endfunction

   // Advance the window by one column and roll the line stores
   function automatic void shift_column(logic [RGB_W-1:0] pix);
      int unsigned      x;
      logic [RGB_W-1:0] from_top, from_mid;
      x = in_x % MAX_W;
      from_top = line_top[x];
      from_mid = line_mid[x];
      for (int r = 0; r < 3; r++) begin
         nbhd[r][0] = nbhd[r][1];
         nbhd[r][1] = nbhd[r][2];
      end
      nbhd[0][2] = from_top;
      nbhd[1][2] = from_mid;
      nbhd[2][2] = pix;
      line_top[x] = line_mid[x];
      line_mid[x] = pix;
   endfunction

   // 2*centre minus zero-padded box blur, per channel, wrapped to a byte
   function automatic logic [RGB_W-1:0] blur_sharpen(int centre);
      logic [RGB_W-1:0] rgb;
      logic [31:0]      diff;
      int               sum, pos, sh;
      rgb = '0;
      for (int ch = 0; ch < 3; ch++) begin
         sh = 16 - 8 * ch;
         sum = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            if (!(dr < 0 && out_y == 0) && !(dr > 0 && out_y + 1 >= frame_h)) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  pos = centre + dc;
                  if (!(dc < 0 && out_x == 0) && !(dc > 0 && out_x + 1 >= frame_w)
                      && pos <= 2)
                     sum += (nbhd[dr + 1][pos] >> sh) & 8'hFF;
               end
            end
         end
         diff = 2 * ((nbhd[1][centre] >> sh) & 8'hFF) - sum / 9;
         rgb = rgb | RGB_W'((diff & 32'hFF) << sh);
      end
      return rgb;
   endfunction

   // Take one accepted word; returns 1 when it releases a result
   function automatic bit sharpen_word(logic act, logic [RGB_W-1:0] pix,
                                       output sharp_pixel_type res);
      bit               emit, last;
      logic [RGB_W-1:0] taken;
      res = '0;
      last = 1'b0;
      taken = '0;
      // Flush ahead of the last pixel is dropped; a pixel past it drains
      if (in_y < frame_h) begin
         if (act == ACT_FLUSH) return 1'b0;
         taken = pix;
      end
      emit = (in_y >= 2) || (in_y == 1 && in_x >= 1);
      if (in_x == 0) begin
         if (emit) {res.red, res.green, res.blue} = blur_sharpen(2);
         shift_column(taken);
      end else begin
         shift_column(taken);
         if (emit) {res.red, res.green, res.blue} = blur_sharpen(1);
      end
      if (emit) begin
         last = (out_y + 1 == frame_h) && (out_x + 1 == frame_w);
         res.frame_end = last;
         out_x++;
         if (out_x >= frame_w) begin
            out_x = 0;
            out_y++;
         end
      end
      in_x++;
      if (in_x >= frame_w) begin
         in_x = 0;
         in_y++;
      end
      if (last) restart_counters();
      return emit;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Watch both channels and the register port at each rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         reset_sharpener();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("result word %0d/%0d/%0d with none expected",
                                         rsp_red_out, rsp_green_out, rsp_blue_out));
            end else begin
               head = pending_pixels.pop_front();
               if (rsp_red_out !== head.red)
                  report_mismatch($sformatf("red got %0d want %0d", rsp_red_out, head.red));
               if (rsp_green_out !== head.green)
                  report_mismatch($sformatf("green got %0d want %0d",
                                            rsp_green_out, head.green));
               if (rsp_blue_out !== head.blue)
                  report_mismatch($sformatf("blue got %0d want %0d", rsp_blue_out, head.blue));
               if (rsp_frame_end !== head.frame_end)
                  report_mismatch($sformatf("frame_end got %0d want %0d",
                                            rsp_frame_end, head.frame_end));
            end
         end
         if (csr_write_en) apply_reg_write(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            if (sharpen_word(req_action, {req_red_in, req_green_in, req_blue_in}, predicted))
               pending_pixels.push_back(pin_valid ? pin_want : predicted);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [PIX_W-1:0] pick_byte();
      int          r;
      logic [31:0] v;
      r = $urandom_range(0, 15);
      v = $urandom;
      if (r == 0) return '0;
      if (r == 1) return '1;
      return v[PIX_W-1:0];
   endfunction

   // Receiver: hold ready low for random stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) hold_left <= pick_gap();
      end
   end

   // Present one word from a falling edge and hold it until taken
   task automatic send_word(action_type act, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                            logic [PIX_W-1:0] b, bit pinned, sharp_pixel_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      pin_valid    <= pinned;
      pin_want     <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid, wait out every expected word and the pipeline tail
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Pixels of a frame with the odd stray flush, then the draining words
   task automatic send_stream(int pixels, int drains);
      for (int i = 0; i < pixels; i++) begin
         if ($urandom_range(0, 31) == 0)
            send_word(ACT_FLUSH, pick_byte(), pick_byte(), pick_byte(), 1'b0, '0);
         send_word(ACT_PIXEL, pick_byte(), pick_byte(), pick_byte(), 1'b0, '0);
         stim_count++;
      end
      for (int i = 0; i < drains; i++) begin
         send_word(($urandom_range(0, 9) == 0) ? ACT_PIXEL : ACT_FLUSH,
                   pick_byte(), pick_byte(), pick_byte(), 1'b0, '0);
         stim_count++;
      end
   endtask

   task automatic add_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{kind: ROW_REG, idx: idx, data: data, act: ACT_PIXEL, red: '0, green: '0,
              blue: '0, pinned: 1'b0, want: '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_word(action_type act, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                           logic [PIX_W-1:0] b, bit pinned, sharp_pixel_type want);
      stim_row_type row;
      row = '{kind: ROW_WORD, idx: '0, data: '0, act: act, red: r, green: g, blue: b,
              pinned: pinned, want: want};
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : run
      int                    w, h, raw_w, raw_h, cut, open_pixels, cur_w, frames;
      logic [CSR_DATA_W-1:0] wdata;

      // Spare index first: must leave the reset frame size alone
      add_reg(REG_UNUSED_HI, 13'h1FFF);
      // Zero in both registers rounds up to a single-pixel frame
      add_reg(bbus_pkg::REG_IMAGE_WIDTH, 13'h0000);
      add_reg(bbus_pkg::REG_IMAGE_HEIGHT, 13'h0000);
      // Flush ahead of the only pixel: dropped
      add_word(ACT_FLUSH, 8'h55, 8'hAA, 8'h0F, 1'b0, '0);
      add_word(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, {8'd226, 8'd226, 8'd226, 1'b1});
      add_word(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd255, 8'd255, 8'd255, 1'b1, {8'd0, 8'd0, 8'd0, 1'b1});
      add_word(ACT_PIXEL, 8'd9, 8'd128, 8'd1, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, {8'd17, 8'd242, 8'd2, 1'b1});
      // Width field bits above the register are dropped, leaving zero
      add_reg(bbus_pkg::REG_IMAGE_WIDTH, 13'h0800);
      add_word(ACT_PIXEL, 8'd255, 8'd0, 8'd128, 1'b0, '0);
      // Pixel past the last one drains like a flush
      add_word(ACT_PIXEL, 8'd7, 8'd7, 8'd7, 1'b0, '0);
      add_word(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, {8'd226, 8'd0, 8'd242, 1'b1});
      // Small 3x2 frame of extremes
      add_reg(bbus_pkg::REG_IMAGE_WIDTH, 13'd3);
      add_reg(bbus_pkg::REG_IMAGE_HEIGHT, 13'd2);
      add_word(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0);
      add_word(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0);
      add_word(ACT_PIXEL, 8'd255, 8'd0, 8'd255, 1'b0, '0);
      add_word(ACT_PIXEL, 8'd0, 8'd255, 8'd0, 1'b0, '0);
      add_word(ACT_PIXEL, 8'd128, 8'd1, 8'd254, 1'b0, '0);
      add_word(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0);
      repeat (4) add_word(ACT_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            wait_quiet();
            write_reg(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_word(directed_rows[i].act, directed_rows[i].red, directed_rows[i].green,
                      directed_rows[i].blue, directed_rows[i].pinned, directed_rows[i].want);
         end
      end

      // Tall frame: height above the maximum clamps to it; abandon in row four
      wait_quiet();
      write_reg(bbus_pkg::REG_IMAGE_WIDTH, 13'd3);
      write_reg(bbus_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
      send_stream(12, 0);

      // Random phases of small frames
      stim_count = 0;
      open_pixels = 0;
      cur_w = 1;
      while (stim_count < RANDOM_ITEMS) begin
         wait_quiet();
         steady = ($urandom_range(0, 3) == 0);
         if (open_pixels > 0 && $urandom_range(0, 2) == 0) begin
            // Spare index mid-frame: the open frame carries on
            wdata = CSR_DATA_W'($urandom);
            write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_LO : REG_UNUSED_HI, wdata);
            send_stream(open_pixels, cur_w + 1);
            open_pixels = 0;
         end else begin
            w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            raw_w = ($urandom_range(0, 15) == 0) ? 0 : w;
            raw_h = ($urandom_range(0, 15) == 0) ? 0 : h;
            if (raw_w == 0) w = 1;
            if (raw_h == 0) h = 1;
            cur_w = w;
            wdata = CSR_DATA_W'(raw_w);
            wdata[CSR_DATA_W-1:WIDTH_REG_BITS] =
               (CSR_DATA_W-WIDTH_REG_BITS)'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) begin
               write_reg(bbus_pkg::REG_IMAGE_WIDTH, wdata);
               write_reg(bbus_pkg::REG_IMAGE_HEIGHT, CSR_DATA_W'(raw_h));
            end else begin
               write_reg(bbus_pkg::REG_IMAGE_HEIGHT, CSR_DATA_W'(raw_h));
               write_reg(bbus_pkg::REG_IMAGE_WIDTH, wdata);
            end
            frames = $urandom_range(1, 2);
            repeat (frames) send_stream(w * h, w + 1);
            open_pixels = 0;
            // Sometimes leave a frame half sent for the next phase
            if (w * h > 1 && $urandom_range(0, 3) == 0) begin
               cut = $urandom_range(1, w * h - 1);
               send_stream(cut, 0);
               open_pixels = w * h - cut;
            end
         end
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
